// ===== rtl/core/icprng_pkg.sv =====
// Shared types, constants and microcode ROM for the inversive congruential generator.
package icprng_pkg;

	// Generator constants
	localparam logic [63:0] MULT_K     = 64'd6906969069;
	localparam logic [63:0] ADD_K      = 64'd1234513250;
	localparam logic [63:0] SEED_RESET = 64'd12345;
	localparam logic [63:0] TWO_K      = 64'd2;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;
	localparam logic REG_IDX_SEED = 1'b0;

	// Sequencer sizing
	localparam int PC_W   = 4;
	localparam int ITER_W = 2;
	localparam logic [PC_W-1:0]   PC_FIRST  = 4'd0;
	localparam logic [PC_W-1:0]   PC_LOOP   = 4'd1;
	localparam logic [ITER_W-1:0] ITER_LAST = 2'd3;

	// Control state
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Which 32x32 partial product to form
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LL,
		MUL_LH,
		MUL_HL
	} mul_t;

	// Second multiplier operand
	typedef enum logic [1:0] {
		B_X,
		B_T,
		B_C
	} bsel_t;

	// Accumulator action
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADDHI
	} acc_t;

	// Register write-back
	typedef enum logic [2:0] {
		WB_NONE,
		WB_INIT,
		WB_T,
		WB_Y,
		WB_STATE
	} wb_t;

	// One microcode word
	typedef struct packed {
		mul_t  mul;
		bsel_t bsel;
		acc_t  acc;
		wb_t   wb;
		logic  jmp;
		logic  fin;
	} ctl_t;

	// Program: initial guess, four Newton passes, then the affine step.
	// Each 64-bit product takes LL, LH, HL partials and a final add.
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t c;
		c = '{MUL_NONE, B_X, ACC_HOLD, WB_NONE, 1'b0, 1'b0};
		case (pc)
			4'd0: c = '{MUL_NONE, B_X, ACC_HOLD,  WB_INIT,  1'b0, 1'b0};
			// t = 2 - y*x
			4'd1: c = '{MUL_LL,   B_X, ACC_HOLD,  WB_NONE,  1'b0, 1'b0};
			4'd2: c = '{MUL_LH,   B_X, ACC_LOAD,  WB_NONE,  1'b0, 1'b0};
			4'd3: c = '{MUL_HL,   B_X, ACC_ADDHI, WB_NONE,  1'b0, 1'b0};
			4'd4: c = '{MUL_NONE, B_X, ACC_ADDHI, WB_NONE,  1'b0, 1'b0};
			4'd5: c = '{MUL_NONE, B_X, ACC_HOLD,  WB_T,     1'b0, 1'b0};
			// y = y*t, loop back until four passes are done
			4'd6: c = '{MUL_LL,   B_T, ACC_HOLD,  WB_NONE,  1'b0, 1'b0};
			4'd7: c = '{MUL_LH,   B_T, ACC_LOAD,  WB_NONE,  1'b0, 1'b0};
			4'd8: c = '{MUL_HL,   B_T, ACC_ADDHI, WB_NONE,  1'b0, 1'b0};
			4'd9: c = '{MUL_NONE, B_T, ACC_ADDHI, WB_NONE,  1'b0, 1'b0};
			4'd10: c = '{MUL_NONE, B_T, ACC_HOLD, WB_Y,     1'b1, 1'b0};
			// state = K*y + A
			4'd11: c = '{MUL_LL,   B_C, ACC_HOLD,  WB_NONE,  1'b0, 1'b0};
			4'd12: c = '{MUL_LH,   B_C, ACC_LOAD,  WB_NONE,  1'b0, 1'b0};
			4'd13: c = '{MUL_HL,   B_C, ACC_ADDHI, WB_NONE,  1'b0, 1'b0};
			4'd14: c = '{MUL_NONE, B_C, ACC_ADDHI, WB_NONE,  1'b0, 1'b0};
			4'd15: c = '{MUL_NONE, B_C, ACC_HOLD,  WB_STATE, 1'b0, 1'b1};
			default: c = '{MUL_NONE, B_X, ACC_HOLD, WB_NONE, 1'b0, 1'b0};
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/inversive_congruential_prng64.sv =====
// A word is valid once the request is accepted and the microcode program has run to its
// final step. One request is in flight at a time: no new request is taken until the word is
// written. The program length is set by the single shared 32x32 multiplier: nine 64-bit
// products, each three partial products, an accumulate step and a write-back, plus the initial guess step.
// An unclaimed previous word holds the final step until it is taken.
// Reset (arst_n low, asynchronous): seed = 12345, state = 12345, sequencer idle, no word pending.
module inversive_congruential_prng64 (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             restart,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [31:0]                      random_word,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [icprng_pkg::ADDR_W-1:0]    paddr,
	input  logic [icprng_pkg::DATA_W-1:0]    pwdata,
	output logic [icprng_pkg::DATA_W-1:0]    prdata,
	output logic                             pready
);

	icprng_pkg::state_t                  state_q, state_d;
	logic [icprng_pkg::PC_W-1:0]         pc_q;
	logic [icprng_pkg::ITER_W-1:0]       iter_q;
	icprng_pkg::ctl_t                    cw;
	logic                                req_fire;
	logic                                stall;
	logic                                go;
	logic [63:0]                         seed_q;
	logic [63:0]                         x_q, y_q, t_q, acc_q, prod_q;
	logic [63:0]                         b_full;
	logic [31:0]                         mul_a, mul_b;
	logic [63:0]                         new_state;
	logic                                rsp_valid_q;
	logic [31:0]                         word_q;

	// Configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[3] == icprng_pkg::REG_IDX_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= icprng_pkg::SEED_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[3] == icprng_pkg::REG_IDX_SEED) begin
			seed_q <= pwdata;
		end
	end

	// Control word for the current step
	assign cw       = icprng_pkg::ucode(pc_q);
	assign req_fire = req_valid && req_ready;
	// hold the last step while the previous word is still unclaimed
	assign stall    = (cw.wb == icprng_pkg::WB_STATE) && rsp_valid_q && !rsp_ready;

	// FSM next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			icprng_pkg::ST_IDLE: begin
				if (req_fire) state_d = icprng_pkg::ST_RUN;
			end
			icprng_pkg::ST_RUN: begin
				if (cw.fin && !stall) state_d = icprng_pkg::ST_IDLE;
			end
			default: state_d = icprng_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req_ready = 1'b0;
		go        = 1'b0;
		case (state_q)
			icprng_pkg::ST_IDLE: req_ready = 1'b1;
			icprng_pkg::ST_RUN:  go = !stall;
			default: begin
				req_ready = 1'b0;
				go        = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icprng_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step counter with the Newton loop jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= icprng_pkg::PC_FIRST;
			iter_q <= '0;
		end else if (req_fire) begin
			pc_q   <= icprng_pkg::PC_FIRST;
			iter_q <= '0;
		end else if (go) begin
			if (cw.jmp && iter_q != icprng_pkg::ITER_LAST) begin
				pc_q   <= icprng_pkg::PC_LOOP;
				iter_q <= iter_q + 1'b1;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// Multiplier operand selection
	always_comb begin
		case (cw.bsel)
			icprng_pkg::B_X: b_full = x_q;
			icprng_pkg::B_T: b_full = t_q;
			icprng_pkg::B_C: b_full = icprng_pkg::MULT_K;
			default:         b_full = x_q;
		endcase
		mul_a = (cw.mul == icprng_pkg::MUL_HL) ? y_q[63:32] : y_q[31:0];
		mul_b = (cw.mul == icprng_pkg::MUL_LH) ? b_full[63:32] : b_full[31:0];
	end

	// Shared 32x32 multiplier, registered product
	always_ff @(posedge clk) begin
		if (go && cw.mul != icprng_pkg::MUL_NONE) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
	end

	// Accumulator: low product loads, cross products add into the upper half
	always_ff @(posedge clk) begin
		if (go) begin
			case (cw.acc)
				icprng_pkg::ACC_LOAD:  acc_q <= prod_q;
				icprng_pkg::ACC_ADDHI: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				default:               acc_q <= acc_q;
			endcase
		end
	end

	assign new_state = acc_q + icprng_pkg::ADD_K;

	// Estimate and Newton term write-back
	always_ff @(posedge clk) begin
		if (go) begin
			case (cw.wb)
				icprng_pkg::WB_INIT: y_q <= (x_q + {x_q[62:0], 1'b0}) ^ icprng_pkg::TWO_K;
				icprng_pkg::WB_T:    t_q <= icprng_pkg::TWO_K - acc_q;
				icprng_pkg::WB_Y:    y_q <= acc_q;
				default: begin
					y_q <= y_q;
					t_q <= t_q;
				end
			endcase
		end
	end

	// Generator state: restart load on accept, new value at the end of the program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= icprng_pkg::SEED_RESET | 64'd1;
		end else if (req_fire && restart) begin
			x_q <= seed_q | 64'd1;
		end else if (go && cw.wb == icprng_pkg::WB_STATE) begin
			x_q <= new_state;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go && cw.wb == icprng_pkg::WB_STATE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.wb == icprng_pkg::WB_STATE) begin
			word_q <= new_state[63:32];
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign random_word = word_q;

endmodule

// ===== rtl/core/icprng_checker.sv =====
// Port-level checks for the inversive congruential generator, bound to the top level.
module icprng_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [31:0]                   random_word
);

	// a pending word holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(random_word)))
		else $error("response word dropped or changed while stalled");

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a step is in progress");

	// a fresh word appears only as the sequencer goes idle
	a_word_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> (req_ready && $past(!req_ready)))
		else $error("response word without a finished step");

	// no word is ready early after an accept that found none pending
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !rsp_valid) |-> ##2 !rsp_valid)
		else $error("response word too early");

endmodule

bind inversive_congruential_prng64 icprng_checker u_icprng_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.random_word (random_word)
);
